// ----- hw/rtl/mcca_pkg.sv -----
// Shared types and constants for the Monte Carlo covariance accumulator.
// Used by mcca_ctrl, mcca_datapath and the core top level; no dependencies.
package mcca_pkg;

    localparam logic [1:0] CMD_NOM   = 2'd0;
    localparam logic [1:0] CMD_SHIFT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [32:0] EPS_Q16   = 33'd655;
    localparam logic [57:0] ONE_Q24   = 58'd16777216;
    localparam logic [31:0] SHIFT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INV_RESET = 32'd42950;

    localparam logic [5:0] DIV_STEPS = 6'd57;
    localparam logic [5:0] DRAIN_CYC = 6'd5;

    typedef struct packed {
        logic nom_wr;
        logic nom_rd;
        logic cov_rd;
        logic div_init;
        logic div_step;
        logic shift_wr;
        logic si_load;
        logic acc_issue;
        logic clr_issue;
        logic out_read;
        logic out_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic last;
    } t_dp_sts;

endpackage

// ----- hw/rtl/mc_covariance_accumulator_core.sv -----
// Top level of the Monte Carlo covariance accumulator core.
// Instantiates mcca_ctrl and mcca_datapath; uses mcca_pkg.
// After reset the covariance store is swept to zero, one entry a cycle; no
// item is taken until that ends. A read waits for the output register to be
// free, and a shifted load runs the one-bit-per-cycle divider before its
// shift is stored. A shifted load flagged last then sweeps the matrix through
// the scaling and accumulate pipeline, one entry a cycle except for a fetch
// of the row shift before each row, then drains before the completion item.
module mc_covariance_accumulator_core import mcca_pkg::*; #(
    parameter int NUM_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // row_index[5:0], col_index[11:6], bin_value[43:12]
    input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // cov_entry[63:0]
    output logic        m_axis_tuser,  // result_kind[0]
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int CW    = $clog2(NUM_BINS * NUM_BINS);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [IDX_W-1:0] w_i, w_j;

    mcca_ctrl #(
        .NUM_BINS (NUM_BINS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .o_i        (w_i),
        .o_j        (w_j)
    );

    mcca_datapath #(
        .NUM_BINS (NUM_BINS),
        .IDX_W    (IDX_W),
        .CW       (CW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_i         (w_i),
        .i_j         (w_j),
        .i_row       (s_axis_tdata[5:0]),
        .i_col       (s_axis_tdata[11:6]),
        .i_val       (s_axis_tdata[43:12]),
        .i_last      (s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/mcca_ctrl.sv -----
// Controller for the covariance accumulator: clearing sweep, command decode,
// divider sequencing and the row/column accumulation sweep. Uses mcca_pkg.
module mcca_ctrl import mcca_pkg::*; #(
    parameter int NUM_BINS = 64,
    parameter int IDX_W    = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_cmd,
    input  t_dp_sts          i_sts,
    output logic             o_in_ready,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_i,
    output logic [IDX_W-1:0] o_j
);

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DIV_INIT = 4'd2;
    localparam logic [3:0] ST_DIV      = 4'd3;
    localparam logic [3:0] ST_DIV_END  = 4'd4;
    localparam logic [3:0] ST_ROW      = 4'd5;
    localparam logic [3:0] ST_RUN      = 4'd6;
    localparam logic [3:0] ST_DRAIN    = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;
    localparam logic [3:0] ST_RD       = 4'd9;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [5:0]       r_cnt, n_cnt;
    logic             w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_i        = r_i;
    assign o_j        = r_j;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_issue = 1'b1;
                if (r_j == LAST_IDX) begin
                    n_j = '0;
                    if (r_i == LAST_IDX) begin
                        n_i     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_cmd)
                        CMD_NOM: o_cmd.nom_wr = 1'b1;
                        CMD_SHIFT: begin
                            o_cmd.nom_rd = 1'b1;
                            n_state      = ST_DIV_INIT;
                        end
                        CMD_READ: begin
                            o_cmd.cov_rd = 1'b1;
                            n_state      = ST_RD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_STEPS - 1'b1) begin
                    n_state = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                o_cmd.shift_wr = 1'b1;
                n_i            = '0;
                n_j            = '0;
                n_state        = i_sts.last ? ST_ROW : ST_IDLE;
            end
            ST_ROW: begin
                o_cmd.si_load = 1'b1;
                n_j           = '0;
                n_state       = ST_RUN;
            end
            ST_RUN: begin
                o_cmd.acc_issue = 1'b1;
                if (r_j == LAST_IDX) begin
                    n_j = '0;
                    if (r_i == LAST_IDX) begin
                        n_i     = '0;
                        n_cnt   = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_ROW;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DRAIN_CYC - 1'b1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_done = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_RD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_read = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
        end
    end

    a_issue_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.acc_issue && o_cmd.clr_issue))
        else $error("accumulate and clear issued together");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_read || o_cmd.out_done) |-> !i_sts.out_busy)
        else $error("result loaded into busy output register");

    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_END) |-> ($past(r_state) == ST_DIV))
        else $error("shift written without full division");

endmodule

// ----- hw/rtl/mcca_datapath.sv -----
// Datapath: bin stores, restoring divider, outer-product pipeline with
// saturating accumulate into the covariance store, and output register. Uses mcca_pkg.
module mcca_datapath import mcca_pkg::*; #(
    parameter int NUM_BINS = 64,
    parameter int IDX_W    = 6,
    parameter int CW       = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [IDX_W-1:0] i_i,
    input  logic [IDX_W-1:0] i_j,
    input  logic [5:0]       i_row,
    input  logic [5:0]       i_col,
    input  logic [31:0]      i_val,
    input  logic             i_last,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    input  logic             i_out_ready,
    output t_dp_sts          o_sts,
    output logic             o_out_valid,
    output logic             o_out_kind,
    output logic [63:0]      o_out_data
);

    logic [31:0] nom_mem [NUM_BINS];
    logic [31:0] shift_mem [NUM_BINS];
    logic [63:0] cov_mem [NUM_BINS*NUM_BINS];

    logic [31:0] r_inv;
    logic [5:0]  r_row;
    logic [31:0] r_val;
    logic        r_last;
    logic        r_row_ok;
    logic        r_rd_ok;
    logic [31:0] r_nom_rd;
    logic [31:0] r_shift_rd;
    logic [63:0] r_cov_rd;

    logic [32:0] r_den;
    logic [33:0] r_rem;
    logic [56:0] r_quo;
    logic        r_nzero;

    logic        r_si_ld_d;
    logic [31:0] r_si;

    logic        r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic [CW-1:0] r_a_k, r_b_k, r_c_k, r_d_k;
    logic        r_b_neg, r_c_neg, r_d_neg;
    logic [63:0] r_b_mag, r_b_cov, r_c_cov, r_d_cov;
    logic [63:0] r_c_lo;
    logic [31:0] r_c_mhi;
    logic [63:0] r_d_r;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [63:0] r_out_data;

    logic [IDX_W+5:0] w_row_w, w_col_w, w_rrow_w;
    logic [IDX_W-1:0] w_row_idx, w_rrow_idx;
    logic             w_row_ok, w_col_ok, w_rrow_ok;
    logic [CW+5:0]    w_rd_k_w;
    logic [CW-1:0]    w_rd_k, w_acc_k;
    logic [33:0]      w_trial;
    logic [57:0]      w_diff;
    logic [31:0]      w_shift;
    logic [31:0]      w_abs_i, w_abs_j;
    logic [63:0]      w_hi, w_term, w_sum;
    logic             w_ovf;

    assign w_row_w    = {{IDX_W{1'b0}}, i_row};
    assign w_col_w    = {{IDX_W{1'b0}}, i_col};
    assign w_rrow_w   = {{IDX_W{1'b0}}, r_row};
    assign w_row_idx  = w_row_w[IDX_W-1:0];
    assign w_rrow_idx = w_rrow_w[IDX_W-1:0];
    assign w_row_ok   = w_row_w < (IDX_W+6)'(NUM_BINS);
    assign w_col_ok   = w_col_w < (IDX_W+6)'(NUM_BINS);
    assign w_rrow_ok  = w_rrow_w < (IDX_W+6)'(NUM_BINS);
    assign w_rd_k_w   = (CW+6)'(i_row) * (CW+6)'(NUM_BINS) + (CW+6)'(i_col);
    assign w_rd_k     = w_rd_k_w[CW-1:0];
    assign w_acc_k    = CW'(i_i) * CW'(NUM_BINS) + CW'(i_j);

    assign w_trial = {r_rem[32:0], r_quo[56]} - {1'b0, r_den};
    assign w_diff  = {1'b0, r_quo} - ONE_Q24;
    always_comb begin
        if (r_nzero) begin
            w_shift = '0;
        end else if (!w_diff[57] && (w_diff[56:31] != '0)) begin
            w_shift = SHIFT_MAX;
        end else begin
            w_shift = w_diff[31:0];
        end
    end

    assign w_abs_i = r_si[31] ? (32'd0 - r_si) : r_si;
    assign w_abs_j = r_shift_rd[31] ? (32'd0 - r_shift_rd) : r_shift_rd;
    assign w_hi    = 64'(r_c_mhi) * 64'(r_inv);
    assign w_term  = r_d_neg ? (64'd0 - r_d_r) : r_d_r;
    assign w_sum   = r_d_cov + w_term;
    assign w_ovf   = (r_d_cov[63] == w_term[63]) && (w_sum[63] != r_d_cov[63]);

    // configuration and captured item fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= INV_RESET;
        end else if (i_cfg_we) begin
            r_inv <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.nom_rd) begin
            r_row    <= i_row;
            r_val    <= i_val;
            r_last   <= i_last;
        end
        if (i_cmd.cov_rd) begin
            r_rd_ok <= w_row_ok && w_col_ok;
        end
        r_row_ok <= w_rrow_ok;
    end

    // nominal store
    always_ff @(posedge i_clk) begin
        if (i_cmd.nom_wr && w_row_ok) begin
            nom_mem[w_row_idx] <= i_val;
        end
        if (i_cmd.nom_rd) begin
            r_nom_rd <= nom_mem[w_row_idx];
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_den   <= 33'(r_nom_rd) + EPS_Q16;
            r_rem   <= '0;
            r_quo   <= {33'(r_val) + EPS_Q16, 24'd0};
            r_nzero <= (r_nom_rd == '0);
        end else if (i_cmd.div_step) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[55:0], 1'b1};
            end else begin
                r_rem <= {r_rem[32:0], r_quo[56]};
                r_quo <= {r_quo[55:0], 1'b0};
            end
        end
    end

    // shift store
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_wr && r_row_ok) begin
            shift_mem[w_rrow_idx] <= w_shift;
        end
        if (i_cmd.si_load) begin
            r_shift_rd <= shift_mem[i_i];
        end else if (i_cmd.acc_issue) begin
            r_shift_rd <= shift_mem[i_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si_ld_d <= 1'b0;
        end else begin
            r_si_ld_d <= i_cmd.si_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_si_ld_d) begin
            r_si <= r_shift_rd;
        end
    end

    // covariance store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_issue) begin
            cov_mem[w_acc_k] <= '0;
        end else if (r_d_vld) begin
            cov_mem[r_d_k] <= w_ovf ? {r_d_cov[63], {63{~r_d_cov[63]}}} : w_sum;
        end
        if (i_cmd.cov_rd) begin
            r_cov_rd <= cov_mem[w_rd_k];
        end else if (i_cmd.acc_issue) begin
            r_cov_rd <= cov_mem[w_acc_k];
        end
    end

    // term pipeline: |si*sj|, low/high scaling, sign and saturating add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.acc_issue;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_k   <= w_acc_k;
        r_b_k   <= r_a_k;
        r_b_mag <= 64'(w_abs_i) * 64'(w_abs_j);
        r_b_neg <= r_si[31] ^ r_shift_rd[31];
        r_b_cov <= r_cov_rd;
        r_c_k   <= r_b_k;
        r_c_lo  <= 64'(r_b_mag[31:0]) * 64'(r_inv);
        r_c_mhi <= r_b_mag[63:32];
        r_c_neg <= r_b_neg;
        r_c_cov <= r_b_cov;
        r_d_k   <= r_c_k;
        r_d_r   <= (w_hi + {32'd0, r_c_lo[63:32]}) >> 16;
        r_d_neg <= r_c_neg;
        r_d_cov <= r_c_cov;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_read || i_cmd.out_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_read) begin
            r_out_kind <= KIND_READ;
            r_out_data <= r_rd_ok ? r_cov_rd : '0;
        end else if (i_cmd.out_done) begin
            r_out_kind <= KIND_DONE;
            r_out_data <= '0;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_sts.last     = r_last;
    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_out_data     = r_out_data;

endmodule

// ----- dv/mc_covariance_accumulator_core_tb.sv -----
// Testbench for mc_covariance_accumulator_core: bin loads, universe accumulation
// and matrix reads checked against an in-bench fixed-point predictor.
// Depends on mcca_pkg and the core RTL only.
`timescale 1ns / 100ps

module mc_covariance_accumulator_core_tb;
    import mcca_pkg::*;

    localparam int BINS = 64;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic        kind;
        logic [63:0] entry;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = CMD_NOM;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    mc_covariance_accumulator_core #(.NUM_BINS(BINS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] inv_scale = INV_RESET;
    logic [31:0] nominal [BINS];
    int          shift [BINS];
    longint      cov [BINS*BINS];
    t_result     pending_results[$];

    int n_items = 0, n_reads = 0, n_universes = 0, n_errors = 0;
    int burst_left = 0;
    bit gap_en = 1'b0;
    int stall_mode = 0;
    int hold_req = 0, hold_seen = 0, hold_cnt = 0, stall_ctr = 0;

    function automatic int frac_shift(logic [31:0] s, logic [31:0] n);
        longint unsigned num, den, ratio, d;
        if (n == 0) return 0;
        num = (64'(s) + 64'(EPS_Q16)) << 24;
        den = 64'(n) + 64'(EPS_Q16);
        ratio = num / den;
        if (ratio >= 64'(ONE_Q24)) begin
            d = ratio - 64'(ONE_Q24);
            if (d > 64'(SHIFT_MAX)) d = 64'(SHIFT_MAX);
            return int'(d);
        end
        return -int'(64'(ONE_Q24) - ratio);
    endfunction

    function automatic longint outer_term(int a, int b);
        longint unsigned ma, mb, mag, hi, lo, r;
        ma = (a < 0) ? longint'(-longint'(a)) : longint'(a);
        mb = (b < 0) ? longint'(-longint'(b)) : longint'(b);
        mag = ma * mb;
        hi = (mag >> 32) * 64'(inv_scale);
        lo = (mag & 64'hFFFF_FFFF) * 64'(inv_scale);
        r = (hi + (lo >> 32)) >> 16;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint sat_add(longint x, longint y);
        longint s;
        s = x + y;
        if (x >= 0 && y >= 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (x < 0 && y < 0 && s >= 0) return 64'h8000_0000_0000_0000;
        return s;
    endfunction

    task automatic predict_item(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                                logic [31:0] val, logic last);
        t_result r;
        case (cmd)
            CMD_NOM: nominal[row] = val;
            CMD_SHIFT: begin
                shift[row] = frac_shift(val, nominal[row]);
                if (last) begin
                    for (int i = 0; i < BINS; i++)
                        for (int j = 0; j < BINS; j++)
                            cov[i*BINS+j] = sat_add(cov[i*BINS+j],
                                                    outer_term(shift[i], shift[j]));
                    r.kind = KIND_DONE;
                    r.entry = '0;
                    pending_results = {pending_results, r};
                    n_universes++;
                end
            end
            CMD_READ: begin
                r.kind = KIND_READ;
                r.entry = cov[int'(row)*BINS + int'(col)];
                pending_results = {pending_results, r};
                n_reads++;
            end
            default: ;
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d entry %h", m_axis_tuser, m_axis_tdata);
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.kind) begin
                    $error("result_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tdata !== e.entry) begin
                    $error("cov_entry: expected %h, got %h", e.entry, m_axis_tdata);
                    n_errors++;
                end
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge i_clk) begin
        stall_ctr <= stall_ctr + 1;
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= (stall_ctr % 7 > 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [5:0] row, logic [5:0] col,
                             logic [31:0] val, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {4'b0, val, col, row};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(cmd, row, col, val, last);
        n_items++;
        if (gap_en && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = $urandom_range(0, 12);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        inv_scale = v;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 1000);
            3, 4: return 32'h0001_0000 + $urandom_range(0, 32'h0000_8000);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_reads();
        send_item(CMD_READ, 6'd0, 6'd0, 32'h0, 1'b0);
        send_item(CMD_READ, 6'd63, 6'd63, 32'hFFFF_FFFF, 1'b1);
        send_item(CMD_READ, 6'd0, 6'd63, 32'h0, 1'b0);
        send_item(CMD_SPARE, 6'd5, 6'd9, 32'h1234_5678, 1'b1);
    endtask

    task automatic test_bin_setup();
        for (int b = 0; b < BINS; b++)
            send_item(CMD_NOM, b[5:0], 6'($urandom), (b == 0) ? 32'h0 :
                      (b == 1) ? 32'hFFFF_FFFF : (b == 2) ? 32'h1 : pick_value(),
                      b == 3);
        for (int b = 0; b < BINS; b++)
            send_item(CMD_SHIFT, b[5:0], 6'($urandom),
                      (b == 1 || b == 4) ? 32'h0 : (b == 2) ? 32'hFFFF_FFFF : pick_value(),
                      b == BINS - 1);
        send_item(CMD_READ, 6'd0, 6'd0, 32'h0, 1'b0);
        send_item(CMD_READ, 6'd2, 6'd2, 32'h0, 1'b0);
        send_item(CMD_READ, 6'd1, 6'd2, 32'h0, 1'b0);
        send_item(CMD_READ, 6'd63, 6'd0, 32'h0, 1'b1);
    endtask

    task automatic run_universe(int nshift);
        logic [5:0] r;
        for (int k = 0; k < nshift; k++) begin
            r = 6'($urandom);
            case ($urandom_range(0, 9))
                0: send_item(CMD_NOM, r, 6'($urandom), pick_value(), 1'($urandom));
                1: send_item(CMD_READ, r, 6'($urandom), $urandom, 1'($urandom));
                2: send_item(CMD_SPARE, r, 6'($urandom), $urandom, 1'($urandom));
                default: ;
            endcase
            send_item(CMD_SHIFT, r, 6'($urandom), pick_value(), k == nshift - 1);
        end
        repeat ($urandom_range(2, 10))
            send_item(CMD_READ, 6'($urandom), 6'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic test_scale_settings();
        logic [31:0] scales [4];
        scales = '{32'h1, 32'hFFFF_FFFF, $urandom, INV_RESET};
        foreach (scales[i]) begin
            drain();
            write_scale(scales[i]);
            run_universe(6);
        end
    endtask

    task automatic test_backpressure();
        stall_mode = 0;
        hold_req++;
        repeat (30) send_item(CMD_READ, 6'($urandom), 6'($urandom), $urandom, 1'b0);
        drain();
    endtask

    task automatic test_random_universes();
        while (n_items < 1200) begin
            stall_mode = $urandom_range(0, 3);
            gap_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) run_universe(BINS);
            else run_universe($urandom_range(1, 12));
            if ($urandom_range(0, 7) == 0) begin
                drain();
                write_scale($urandom_range(0, 1) ? 32'($urandom_range(1, 200000)) : $urandom);
            end
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_reads();
        test_bin_setup();
        test_scale_settings();
        test_backpressure();
        test_random_universes();
        $display("Covered %0d items: %0d matrix reads, %0d universes accumulated,",
                 n_items, n_reads, n_universes);
        $display("with scale changes, receiver stalls and a long output hold-off.");
        if (n_errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mcca_pkg.sv
hw/rtl/mcca_ctrl.sv
hw/rtl/mcca_datapath.sv
hw/rtl/mc_covariance_accumulator_core.sv
dv/mc_covariance_accumulator_core_tb.sv
